FILE: hw/rtl/hmr_pkg.sv
package hmr_pkg;

   localparam int REPORT_BYTES = 64;
   localparam int MAX_MESSAGE  = 7609;
   localparam int CONT_PAYLOAD = REPORT_BYTES - 5;
   localparam int POS_W        = $clog2(REPORT_BYTES);
   localparam int LEN_W        = 13;
   localparam int CHAN_W       = 32;

   // header layout
   localparam int POS_TYPE     = 4;
   localparam int POS_LEN_HI   = 5;
   localparam int POS_LEN_LO   = 6;
   localparam int INIT_FIRST   = 7;
   localparam int CONT_FIRST   = 5;

   localparam logic [7:0] INIT_COMMAND = 8'h86;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_IGNORED  = 3'd1,
      ST_BUSY     = 3'd2,
      ST_BAD_SEQ  = 3'd3,
      ST_BAD_LEN  = 3'd4,
      ST_BAD_CMD  = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [7:0]        payload_byte;
      logic [LEN_W-1:0]  payload_offset;
      logic [CHAN_W-1:0] channel_id;
      logic [7:0]        command_code;
      logic [LEN_W-1:0]  message_length;
      logic              last_of_run;
   } rsp_item_type;

endpackage

FILE: hw/rtl/hmr_req_if.sv
interface hmr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_byte;
   logic       report_start;

   modport source (output valid, output report_byte, output report_start, input ready);
   modport sink   (input valid, input report_byte, input report_start, output ready);
endinterface

FILE: hw/rtl/hmr_rsp_if.sv
interface hmr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  status;
   logic [7:0]  payload_byte;
   logic [12:0] payload_offset;
   logic [31:0] channel_id;
   logic [7:0]  command_code;
   logic [12:0] message_length;
   logic        last_of_run;

   modport source (output valid, output kind, output status, output payload_byte,
                   output payload_offset, output channel_id, output command_code,
                   output message_length, output last_of_run, input ready);
   modport sink   (input valid, input kind, input status, input payload_byte,
                   input payload_offset, input channel_id, input command_code,
                   input message_length, input last_of_run, output ready);
endinterface

FILE: hw/rtl/hmr_out_queue.sv
module hmr_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  hmr_pkg::rsp_item_type push_first,
   input  hmr_pkg::rsp_item_type push_second,
   output logic                 space_ok,
   hmr_rsp_if.source            rsp_chan
);
   import hmr_pkg::*;

   rsp_item_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff,  count_in;
   logic                pop;
   rsp_item_type        head;

   assign pop      = rsp_chan.valid & rsp_chan.ready;
   assign space_ok = count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + (QPTR_W+1)'(push_count) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_ff + QPTR_W'(1)] <= push_second;
      end
   end

   assign head = entries_ff[rd_ptr_ff];

   assign rsp_chan.valid          = count_ff != '0;
   assign rsp_chan.kind           = head.kind;
   assign rsp_chan.status         = head.status;
   assign rsp_chan.payload_byte   = head.payload_byte;
   assign rsp_chan.payload_offset = head.payload_offset;
   assign rsp_chan.channel_id     = head.channel_id;
   assign rsp_chan.command_code   = head.command_code;
   assign rsp_chan.message_length = head.message_length;
   assign rsp_chan.last_of_run    = head.last_of_run;

endmodule

FILE: hw/rtl/hid_message_reassembler_unit.sv
// Latency: a result beat is offered on rsp at the earliest the cycle after its byte is taken.
// Throughput: one report byte per cycle; a four-entry result queue absorbs the
//   extra status beat at the end of each report, and req stalls only while the
//   queue holds more than two beats.
// Reset: synchronous; clears the session, header, position and the result queue.
module hid_message_reassembler_unit (
   input  logic     clock,
   input  logic     reset,
   hmr_req_if.sink  req_chan,
   hmr_rsp_if.source rsp_chan
);
   import hmr_pkg::*;

   logic               open_ff,      open_in;
   logic [CHAN_W-1:0]  open_chan_ff, open_chan_in;
   logic [7:0]         open_cmd_ff,  open_cmd_in;
   logic [LEN_W-1:0]   open_len_ff,  open_len_in;
   logic [7:0]         exp_seq_ff,   exp_seq_in;
   logic [LEN_W-1:0]   bytes_ff,     bytes_in;
   logic [POS_W-1:0]   pos_ff,       pos_in;
   logic [CHAN_W-1:0]  hdr_chan_ff,  hdr_chan_in;
   logic [7:0]         hdr_type_ff,  hdr_type_in;
   logic [7:0]         len_hi_ff,    len_hi_in;
   status_type         verdict_ff,   verdict_in;

   logic               space_ok;
   logic               accept;
   logic [7:0]         b;
   logic [POS_W-1:0]   pos;
   logic [15:0]        decl_len;
   logic               other_chan;
   logic [POS_W-1:0]   first;
   logic               emit_pay;
   logic               emit_status;
   logic [LEN_W-1:0]   pay_offset;
   logic [1:0]         push_count;
   rsp_item_type       pay_item, stat_item, push_first, push_second;

   assign req_chan.ready = space_ok;
   assign accept = req_chan.valid & space_ok;
   assign b      = req_chan.report_byte;

   always_comb begin
      open_in     = open_ff;
      open_chan_in = open_chan_ff;
      open_cmd_in = open_cmd_ff;
      open_len_in = open_len_ff;
      exp_seq_in  = exp_seq_ff;
      bytes_in    = bytes_ff;
      hdr_chan_in = hdr_chan_ff;
      hdr_type_in = hdr_type_ff;
      len_hi_in   = len_hi_ff;
      verdict_in  = verdict_ff;

      pos        = req_chan.report_start ? '0 : pos_ff;
      decl_len   = {len_hi_ff, b};
      other_chan = hdr_chan_ff != open_chan_ff;

      if (pos < POS_W'(POS_TYPE)) begin
         hdr_chan_in = {hdr_chan_ff[CHAN_W-9:0], b};
      end else if (pos == POS_W'(POS_TYPE)) begin
         hdr_type_in = b;
         if (!b[7]) begin
            if (!open_ff) begin
               verdict_in = ST_IGNORED;
            end else if (other_chan) begin
               verdict_in = ST_BUSY;
            end else if (b != exp_seq_ff) begin
               verdict_in = ST_BAD_SEQ;
            end else if ((bytes_ff >= open_len_ff) ||
                         (({1'b0, bytes_ff} + (LEN_W+1)'(CONT_PAYLOAD)) >
                          (LEN_W+1)'(MAX_MESSAGE))) begin
               verdict_in = ST_BAD_LEN;
            end else begin
               verdict_in = ST_OK;
               exp_seq_in = exp_seq_ff + 8'd1;
            end
         end
      end else if (pos == POS_W'(POS_LEN_HI) && hdr_type_ff[7]) begin
         len_hi_in = b;
      end else if (pos == POS_W'(POS_LEN_LO) && hdr_type_ff[7]) begin
         if (open_ff && other_chan && open_cmd_ff == INIT_COMMAND) begin
            verdict_in = ST_BUSY;
         end else if (open_ff && other_chan && hdr_type_ff != INIT_COMMAND &&
                      open_cmd_ff != INIT_COMMAND) begin
            verdict_in = ST_BUSY;
         end else if (open_ff && !other_chan && hdr_type_ff != INIT_COMMAND) begin
            verdict_in = ST_BAD_SEQ;
         end else if (decl_len > 16'(MAX_MESSAGE)) begin
            verdict_in = ST_BAD_LEN;
         end else begin
            verdict_in   = ST_OK;
            open_in      = 1'b1;
            open_chan_in = hdr_chan_ff;
            open_cmd_in  = hdr_type_ff;
            open_len_in  = decl_len[LEN_W-1:0];
            exp_seq_in   = '0;
            bytes_in     = '0;
         end
      end

      first      = hdr_type_in[7] ? POS_W'(INIT_FIRST) : POS_W'(CONT_FIRST);
      emit_pay   = (pos >= first) && (verdict_in == ST_OK) && (bytes_in < open_len_in);
      pay_offset = bytes_in;
      if (emit_pay) begin
         bytes_in = bytes_in + LEN_W'(1);
      end

      emit_status = pos == POS_W'(REPORT_BYTES - 1);
      pos_in      = emit_status ? '0 : pos + POS_W'(1);

      pay_item.kind           = KIND_PAYLOAD;
      pay_item.status         = ST_OK;
      pay_item.payload_byte   = b;
      pay_item.payload_offset = pay_offset;
      pay_item.channel_id     = open_chan_in;
      pay_item.command_code   = open_cmd_in;
      pay_item.message_length = open_len_in;
      pay_item.last_of_run    = !emit_status;

      stat_item.kind           = KIND_STATUS;
      stat_item.status         = verdict_in;
      stat_item.payload_byte   = '0;
      stat_item.payload_offset = '0;
      stat_item.channel_id     = open_chan_in;
      stat_item.command_code   = open_cmd_in;
      stat_item.message_length = open_len_in;
      stat_item.last_of_run    = 1'b1;

      push_first  = emit_pay ? pay_item : stat_item;
      push_second = stat_item;
      push_count  = accept ? (2'(emit_pay) + 2'(emit_status)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         open_chan_ff <= '0;
         open_cmd_ff  <= '0;
         open_len_ff  <= '0;
         exp_seq_ff   <= '0;
         bytes_ff     <= '0;
         pos_ff       <= '0;
         hdr_chan_ff  <= '0;
         hdr_type_ff  <= '0;
         len_hi_ff    <= '0;
         verdict_ff   <= ST_OK;
      end else if (accept) begin
         open_ff      <= open_in;
         open_chan_ff <= open_chan_in;
         open_cmd_ff  <= open_cmd_in;
         open_len_ff  <= open_len_in;
         exp_seq_ff   <= exp_seq_in;
         bytes_ff     <= bytes_in;
         pos_ff       <= pos_in;
         hdr_chan_ff  <= hdr_chan_in;
         hdr_type_ff  <= hdr_type_in;
         len_hi_ff    <= len_hi_in;
         verdict_ff   <= verdict_in;
      end
   end

   hmr_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second),
      .space_ok    (space_ok),
      .rsp_chan    (rsp_chan)
   );

endmodule
